// ----- rtl/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_pkg: shared constants and types for the HSV to RGB converter
// Holds the hue geometry constants, reciprocal constants and sector codes.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  // Default fixed-point format of saturation, value and hue fraction.
  localparam int FRACTION_BITS_DEF = 8;

  // Hue geometry.
  localparam int HUE_DEG     = 360;
  localparam int SECTOR_DEG  = 60;
  localparam int CHAN_MAX    = 255;

  // Multiple of 360 added to the signed hue so that it becomes non-negative.
  localparam int HUE_OFFSET  = 92 * HUE_DEG;

  // x / 360 == (x * HUE_RECIP) >> HUE_RECIP_SHIFT, exact for x < 2^17.
  localparam int HUE_RECIP_SHIFT = 25;
  localparam int HUE_RECIP       = ((1 << HUE_RECIP_SHIFT) + HUE_DEG - 1) / HUE_DEG;

  // n / 60 estimate (low by at most one for n < 2^22).
  localparam int SECTOR_RECIP_SHIFT = 24;
  localparam int SECTOR_RECIP       = (1 << SECTOR_RECIP_SHIFT) / SECTOR_DEG;
  localparam int SECTOR_RECIP_W     = 19;

  // Hue sector, one per 60 degrees.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

// ----- rtl/hsvrgb_hue_split.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_hue_split: hue reduction pipeline
// Wraps a signed hue into 0..359, then splits it into a sector and a
// truncated fraction of the sector, over six register stages.
// ----------------------------------------------------------------------------
module hsvrgb_hue_split #(
  parameter int FRACTION_BITS = hsvrgb_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic [5:0]                en,
  input  logic signed [15:0]        hue_degrees,
  output hsvrgb_pkg::sector_t       sector,
  output logic [FRACTION_BITS-1:0]  frac
);

  localparam int XW  = 17;
  localparam int NW  = 6 + FRACTION_BITS;
  localparam int PW5 = NW + hsvrgb_pkg::SECTOR_RECIP_W;
  localparam int RS  = hsvrgb_pkg::SECTOR_RECIP_SHIFT;
  localparam int HUE_RECIP_SHIFT_HI = hsvrgb_pkg::HUE_RECIP_SHIFT + 7;

  logic [XW-1:0]         x1_r, x2_r;
  logic [7:0]            qh2_r;
  logic [8:0]            r3_r;
  hsvrgb_pkg::sector_t   sec4_r, sec5_r, sec6_r;
  logic [5:0]            rem4_r, rem5_r;
  logic [FRACTION_BITS-1:0] fq5_r, f6_r;

  logic [XW-1:0]         x_nxt;
  logic [2*XW-1:0]       prod2;
  logic [XW-1:0]         r_full;
  hsvrgb_pkg::sector_t   sec_nxt;
  logic [8:0]            base_nxt;
  logic [8:0]            rem_full;
  logic [PW5-1:0]        prod5;
  logic [NW:0]           resid6;
  logic [FRACTION_BITS-1:0] f_nxt;

  // Stage 1: lift the hue into non-negative range.
  assign x_nxt = XW'(hue_degrees) + XW'(hsvrgb_pkg::HUE_OFFSET);

  // Stage 2: quotient by 360 through the reciprocal.
  assign prod2 = (2*XW)'(x1_r) * (2*XW)'(hsvrgb_pkg::HUE_RECIP);

  // Stage 3: remainder.
  assign r_full = x2_r - XW'(qh2_r) * XW'(hsvrgb_pkg::HUE_DEG);

  // Stage 4: sector by comparison.
  always_comb begin
    if (r3_r >= 9'(5 * hsvrgb_pkg::SECTOR_DEG)) begin
      sec_nxt  = hsvrgb_pkg::SEC_MAG_RED;
      base_nxt = 9'(5 * hsvrgb_pkg::SECTOR_DEG);
    end else if (r3_r >= 9'(4 * hsvrgb_pkg::SECTOR_DEG)) begin
      sec_nxt  = hsvrgb_pkg::SEC_BLU_MAG;
      base_nxt = 9'(4 * hsvrgb_pkg::SECTOR_DEG);
    end else if (r3_r >= 9'(3 * hsvrgb_pkg::SECTOR_DEG)) begin
      sec_nxt  = hsvrgb_pkg::SEC_CYN_BLU;
      base_nxt = 9'(3 * hsvrgb_pkg::SECTOR_DEG);
    end else if (r3_r >= 9'(2 * hsvrgb_pkg::SECTOR_DEG)) begin
      sec_nxt  = hsvrgb_pkg::SEC_GRN_CYN;
      base_nxt = 9'(2 * hsvrgb_pkg::SECTOR_DEG);
    end else if (r3_r >= 9'(hsvrgb_pkg::SECTOR_DEG)) begin
      sec_nxt  = hsvrgb_pkg::SEC_YEL_GRN;
      base_nxt = 9'(hsvrgb_pkg::SECTOR_DEG);
    end else begin
      sec_nxt  = hsvrgb_pkg::SEC_RED_YEL;
      base_nxt = '0;
    end
  end
  assign rem_full = r3_r - base_nxt;

  // Stage 5: fraction estimate, low by at most one.
  assign prod5 = (PW5'(rem4_r) << FRACTION_BITS) * PW5'(hsvrgb_pkg::SECTOR_RECIP);

  // Stage 6: correct the estimate.
  assign resid6 = ((NW + 1)'(rem5_r) << FRACTION_BITS)
                - (NW + 1)'(fq5_r) * (NW + 1)'(hsvrgb_pkg::SECTOR_DEG);
  assign f_nxt  = (resid6 >= (NW + 1)'(hsvrgb_pkg::SECTOR_DEG)) ? fq5_r + 1'b1 : fq5_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1_r <= x_nxt;
    end
    if (en[1]) begin
      x2_r  <= x1_r;
      qh2_r <= prod2[HUE_RECIP_SHIFT_HI:hsvrgb_pkg::HUE_RECIP_SHIFT];
    end
    if (en[2]) begin
      r3_r <= r_full[8:0];
    end
    if (en[3]) begin
      sec4_r <= sec_nxt;
      rem4_r <= rem_full[5:0];
    end
    if (en[4]) begin
      sec5_r <= sec4_r;
      rem5_r <= rem4_r;
      fq5_r  <= prod5[RS+FRACTION_BITS-1:RS];
    end
    if (en[5]) begin
      sec6_r <= sec5_r;
      f6_r   <= f_nxt;
    end
  end

  assign sector = sec6_r;
  assign frac   = f6_r;

endmodule

// ----- rtl/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: HSV to 8-bit RGB pixel converter
// Nine-stage pipeline: hue wrap and sector split, fixed-point p/q/t terms,
// sector selection and scaling to 0..255.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the pipe is full and out_ready is low, and
// passes it through the nine register stages (hue wrap by reciprocal, sector
// split, fraction estimate and correction, then two multiply stages for the
// p/q/t terms and one for selection and scaling). Every stage carries its own
// valid bit and advances whenever the stage after it is empty or moving, so
// bubbles are squeezed out and the input keeps accepting beats while results
// wait at the output, until the whole pipe is full. Hue is any signed degree
// value and wraps modulo 360; saturation and brightness are signed fixed point
// with FRACTION_BITS fraction bits, clamped to 0..1. All truncation follows
// the usual fixed-point HSV formulas: p = v(1-s), q = v(1-sf), t = v(1-s(1-f)),
// channel = x * 255 >> FRACTION_BITS.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
  parameter int FRACTION_BITS = hsvrgb_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_hue_degrees,
  input  logic signed [9:0]  in_saturation,
  input  logic signed [9:0]  in_brightness,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);

  localparam int NUM_STAGES = 9;
  localparam int FB  = FRACTION_BITS;
  localparam int ONE = 1 << FB;
  // Clamped s and v fit in VW bits: either ONE or the largest field value.
  localparam int VW  = (FB + 1 > 9) ? FB + 1 : 9;

  // Pipeline control: one valid bit per stage, enable rippled from the output.
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Hue path: stages 1..6 produce sector and fraction.
  hsvrgb_pkg::sector_t sec6;
  logic [FB-1:0]       f6;

  hsvrgb_hue_split #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_hue (
    .clk         (clk),
    .en          (en[5:0]),
    .hue_degrees (in_hue_degrees),
    .sector      (sec6),
    .frac        (f6)
  );

  // Stage 1: clamp saturation and brightness to 0..ONE.
  logic signed [VW:0] s_ext, v_ext;
  logic [VW-1:0]      s_nxt, v_nxt;

  assign s_ext = (VW + 1)'(in_saturation);
  assign v_ext = (VW + 1)'(in_brightness);

  always_comb begin
    if (s_ext < 0) begin
      s_nxt = '0;
    end else if (s_ext > (VW + 1)'(ONE)) begin
      s_nxt = VW'(ONE);
    end else begin
      s_nxt = s_ext[VW-1:0];
    end
    if (v_ext < 0) begin
      v_nxt = '0;
    end else if (v_ext > (VW + 1)'(ONE)) begin
      v_nxt = VW'(ONE);
    end else begin
      v_nxt = v_ext[VW-1:0];
    end
  end

  // Hold s and v alongside the hue path (stages 1..5).
  logic [VW-1:0] s_pipe_r [5];
  logic [VW-1:0] v_pipe_r [5];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 5; k++) begin
      if (en[k]) begin
        s_pipe_r[k] <= (k == 0) ? s_nxt : s_pipe_r[(k == 0) ? 0 : k - 1];
        v_pipe_r[k] <= (k == 0) ? v_nxt : v_pipe_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // Stage 6: p = v * (1 - s).
  logic [2*VW-1:0] p_prod;
  logic [VW-1:0]   p6_r, s6_r, v6_r;

  assign p_prod = (2*VW)'(v_pipe_r[4]) * ((2*VW)'(ONE) - (2*VW)'(s_pipe_r[4]));

  always_ff @(posedge clk) begin
    if (en[5]) begin
      p6_r <= p_prod[FB+VW-1:FB];
      s6_r <= s_pipe_r[4];
      v6_r <= v_pipe_r[4];
    end
  end

  // Stage 7: s * f and s * (1 - f).
  logic [VW+FB:0]      sf_prod, sg_prod;
  logic [VW-1:0]       a7_r, b7_r, p7_r, v7_r;
  hsvrgb_pkg::sector_t sec7_r;

  assign sf_prod = (VW + FB + 1)'(s6_r) * (VW + FB + 1)'(f6);
  assign sg_prod = (VW + FB + 1)'(s6_r) * ((VW + FB + 1)'(ONE) - (VW + FB + 1)'(f6));

  always_ff @(posedge clk) begin
    if (en[6]) begin
      a7_r   <= sf_prod[FB+VW-1:FB];
      b7_r   <= sg_prod[FB+VW-1:FB];
      p7_r   <= p6_r;
      v7_r   <= v6_r;
      sec7_r <= sec6;
    end
  end

  // Stage 8: q = v * (1 - s f), t = v * (1 - s (1 - f)).
  logic [2*VW-1:0]     q_prod, t_prod;
  logic [VW-1:0]       q8_r, t8_r, p8_r, v8_r;
  hsvrgb_pkg::sector_t sec8_r;

  assign q_prod = (2*VW)'(v7_r) * ((2*VW)'(ONE) - (2*VW)'(a7_r));
  assign t_prod = (2*VW)'(v7_r) * ((2*VW)'(ONE) - (2*VW)'(b7_r));

  always_ff @(posedge clk) begin
    if (en[7]) begin
      q8_r   <= q_prod[FB+VW-1:FB];
      t8_r   <= t_prod[FB+VW-1:FB];
      p8_r   <= p8_nxt_hold(p7_r);
      v8_r   <= v7_r;
      sec8_r <= sec7_r;
    end
  end

  function automatic logic [VW-1:0] p8_nxt_hold(input logic [VW-1:0] p);
    return p;
  endfunction

  // Stage 9: route terms by sector, scale by 255, drop the fraction.
  logic [VW-1:0]   r_sel, g_sel, b_sel;
  logic [VW+7:0]   r_scl, g_scl, b_scl;
  logic [7:0]      red_r, green_r, blue_r;

  always_comb begin
    case (sec8_r)
      hsvrgb_pkg::SEC_YEL_GRN: begin
        r_sel = q8_r; g_sel = v8_r; b_sel = p8_r;
      end
      hsvrgb_pkg::SEC_GRN_CYN: begin
        r_sel = p8_r; g_sel = v8_r; b_sel = t8_r;
      end
      hsvrgb_pkg::SEC_CYN_BLU: begin
        r_sel = p8_r; g_sel = q8_r; b_sel = v8_r;
      end
      hsvrgb_pkg::SEC_BLU_MAG: begin
        r_sel = t8_r; g_sel = p8_r; b_sel = v8_r;
      end
      hsvrgb_pkg::SEC_MAG_RED: begin
        r_sel = v8_r; g_sel = p8_r; b_sel = q8_r;
      end
      default: begin
        r_sel = v8_r; g_sel = t8_r; b_sel = p8_r;
      end
    endcase
  end

  assign r_scl = (VW + 8)'(r_sel) * (VW + 8)'(hsvrgb_pkg::CHAN_MAX);
  assign g_scl = (VW + 8)'(g_sel) * (VW + 8)'(hsvrgb_pkg::CHAN_MAX);
  assign b_scl = (VW + 8)'(b_sel) * (VW + 8)'(hsvrgb_pkg::CHAN_MAX);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      red_r   <= r_scl[FB+7:FB];
      green_r <= g_scl[FB+7:FB];
      blue_r  <= b_scl[FB+7:FB];
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // An empty output stage must open the whole pipe to new beats.
  a_empty_out_opens_input: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NUM_STAGES-1] |-> in_ready)
    else $error("input stalled with empty output stage");

  // A stalled, occupied stage 5 keeps its beat.
  a_stall_keeps_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && !en[4]) |=> vld_r[4])
    else $error("beat lost in stalled stage");

  // Zero brightness gives black.
  a_black_on_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (en[8] && vld_r[7] && v8_r == '0) |=>
      (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
    else $error("nonzero channel with zero brightness");

endmodule
